>>> rtl/fip_pkg.sv
`timescale 1ns / 1ps
// Package for the float integer power block: shared types, state encodings,
// IEEE double constants and a leading-zero count. No dependencies.
package fip_pkg;

    localparam logic [63:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_DEF_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] DBL_INF     = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_QUIET   = 64'h0008_0000_0000_0000;

    typedef enum logic [0:0] {
        FOP_MUL,
        FOP_RECIP
    } fpu_op_t;

    typedef struct packed {
        logic        start;
        fpu_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } fip_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fip_rsp_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_UNPACK,
        F_MUL,
        F_DIV,
        F_NORM,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_SQ_GO,
        T_SQ_WAIT,
        T_MB_GO,
        T_MB_WAIT,
        T_STEP,
        T_DIV_GO,
        T_DIV_WAIT,
        T_OUT
    } top_state_t;

    // Leading zeros of a 52-bit fraction; meaningful for a nonzero value.
    function automatic logic [5:0] lzc52(input logic [51:0] f);
        logic [5:0] lz;
        lz = 6'd52;
        for (int i = 0; i < 52; i++) begin
            if (f[i]) begin
                lz = 6'(51 - i);
            end
        end
        return lz;
    endfunction

endpackage

>>> rtl/fip_in_if.sv
`timescale 1ns / 1ps
// Input channel of the float integer power block: base and exponent.
// Stands alone; no package needed.
interface fip_in_if #(
    parameter int PowerWidth = 32
);
    logic                  valid;
    logic                  ready;
    logic [63:0]           base_bits;
    logic [PowerWidth-1:0] power;

    modport source (output valid, output base_bits, output power, input ready);
    modport sink   (input valid, input base_bits, input power, output ready);
endinterface

>>> rtl/fip_out_if.sv
`timescale 1ns / 1ps
// Output channel of the float integer power block: the result pattern.
// Stands alone; no package needed.
interface fip_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

>>> rtl/fip_fpu.sv
`timescale 1ns / 1ps
// Multi-cycle IEEE double unit: a*b and 1/a, round to nearest even.
// Uses fip_pkg for the request, response and state types.
module fip_fpu (
    input  logic             clk,
    input  logic             rst_n,
    input  fip_pkg::fip_req_t req,
    output fip_pkg::fip_rsp_t rsp
);
    import fip_pkg::*;

    fpu_state_t          state_reg, state_next;
    logic [5:0]          cnt_reg, cnt_next;
    fpu_op_t             op_reg, op_next;
    logic [63:0]         a_reg, a_next, b_reg, b_next;
    logic                sign_reg, sign_next;
    logic signed [13:0]  ea_reg, ea_next, eb_reg, eb_next;
    logic [52:0]         ma_reg, ma_next, mb_reg, mb_next;
    logic [105:0]        prod_reg, prod_next;
    logic [53:0]         rem_reg, rem_next;
    logic [55:0]         sig_reg, sig_next;
    logic                stk_reg, stk_next;
    logic signed [13:0]  exp_reg, exp_next;
    logic [63:0]         res_reg, res_next;

    // Operand classification and normalization.
    logic        sa, sb;
    logic [10:0] fea, feb;
    logic [51:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [5:0]  lz_a, lz_b;
    logic [52:0] ma_n, mb_n;
    logic signed [13:0] ea_n, eb_n;
    logic        spec;
    logic [63:0] spec_val;

    assign sa  = a_reg[63];
    assign sb  = b_reg[63];
    assign fea = a_reg[62:52];
    assign feb = b_reg[62:52];
    assign fa  = a_reg[51:0];
    assign fb  = b_reg[51:0];
    assign a_nan  = (fea == 11'h7FF) && (fa != '0);
    assign b_nan  = (feb == 11'h7FF) && (fb != '0);
    assign a_inf  = (fea == 11'h7FF) && (fa == '0);
    assign b_inf  = (feb == 11'h7FF) && (fb == '0);
    assign a_zero = (fea == '0) && (fa == '0);
    assign b_zero = (feb == '0) && (fb == '0);
    assign lz_a = lzc52(fa);
    assign lz_b = lzc52(fb);

    always_comb
    begin
        if (fea == '0)
        begin
            ma_n = {1'b0, fa} << (lz_a + 6'd1);
            ea_n = -14'sd1023 - $signed({8'b0, lz_a});
        end
        else
        begin
            ma_n = {1'b1, fa};
            ea_n = $signed({3'b0, fea}) - 14'sd1023;
        end
        if (feb == '0)
        begin
            mb_n = {1'b0, fb} << (lz_b + 6'd1);
            eb_n = -14'sd1023 - $signed({8'b0, lz_b});
        end
        else
        begin
            mb_n = {1'b1, fb};
            eb_n = $signed({3'b0, feb}) - 14'sd1023;
        end
    end

    // NaNs propagate quieted, left operand first; inf times zero is the default NaN.
    always_comb
    begin
        spec     = 1'b1;
        spec_val = '0;
        if (op_reg == FOP_MUL)
        begin
            if (a_nan)
                spec_val = a_reg | DBL_QUIET;
            else if (b_nan)
                spec_val = b_reg | DBL_QUIET;
            else if ((a_inf && b_zero) || (a_zero && b_inf))
                spec_val = DBL_DEF_NAN;
            else if (a_inf || b_inf)
                spec_val = {sa ^ sb, DBL_INF[62:0]};
            else if (a_zero || b_zero)
                spec_val = {sa ^ sb, 63'b0};
            else
                spec = 1'b0;
        end
        else
        begin
            if (a_nan)
                spec_val = a_reg | DBL_QUIET;
            else if (a_inf)
                spec_val = {sa, 63'b0};
            else if (a_zero)
                spec_val = {sa, DBL_INF[62:0]};
            else
                spec = 1'b0;
        end
    end

    // One 27x27 partial product per cycle.
    logic [26:0]  opx, opy;
    logic [53:0]  pp;
    logic [105:0] pp_sh;

    assign opx = cnt_reg[0] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
    assign opy = cnt_reg[1] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
    assign pp  = opx * opy;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {52'b0, pp};
            2'd3:    pp_sh = {pp[51:0], 54'b0};
            default: pp_sh = {25'b0, pp, 27'b0};
        endcase
    end

    // Restoring division step.
    logic [53:0] trial;
    logic        ge;
    assign trial = {rem_reg[52:0], 1'b0};
    assign ge    = trial >= {1'b0, ma_reg};

    // Subnormal alignment, rounding and packing.
    logic               under;
    logic signed [13:0] shift_amt;
    logic [5:0]         sh;
    logic [111:0]       wide;
    logic [55:0]        s_al;
    logic               st_al, rnd_inc;
    logic [53:0]        sum;
    logic signed [13:0] biased;
    logic [63:0]        packed_res;

    always_comb
    begin
        under     = exp_reg < -14'sd1022;
        shift_amt = -14'sd1022 - exp_reg;
        if (!under)
            sh = '0;
        else if (shift_amt > 14'sd63)
            sh = 6'd63;
        else
            sh = shift_amt[5:0];
        wide    = {sig_reg, 56'b0} >> sh;
        s_al    = wide[111:56];
        st_al   = stk_reg | (|wide[55:0]) | s_al[1] | s_al[0];
        rnd_inc = s_al[2] & (st_al | s_al[3]);
        sum     = {1'b0, s_al[55:3]} + {53'b0, rnd_inc};
        biased  = exp_reg + 14'sd1023 + $signed({13'b0, sum[53]});
        if (under)
            packed_res = {sign_reg, 10'b0, sum[52], sum[51:0]};
        else if (biased >= 14'sd2047)
            packed_res = {sign_reg, DBL_INF[62:0]};
        else
            packed_res = {sign_reg, biased[10:0], sum[53] ? 52'b0 : sum[51:0]};
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sign_next  = sign_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        sig_next   = sig_reg;
        stk_next   = stk_reg;
        exp_next   = exp_reg;
        res_next   = res_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    op_next    = req.op;
                    state_next = F_UNPACK;
                end
            end
            F_UNPACK:
            begin
                sign_next = (op_reg == FOP_MUL) ? (sa ^ sb) : sa;
                ea_next   = ea_n;
                eb_next   = eb_n;
                ma_next   = ma_n;
                mb_next   = mb_n;
                prod_next = '0;
                rem_next  = 54'd1 << 51;
                cnt_next  = '0;
                if (spec)
                begin
                    res_next   = spec_val;
                    state_next = F_DONE;
                end
                else if (op_reg == FOP_MUL)
                    state_next = F_MUL;
                else
                    state_next = F_DIV;
            end
            F_MUL:
            begin
                prod_next = prod_reg + pp_sh;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                    state_next = F_NORM;
            end
            F_DIV:
            begin
                rem_next  = ge ? (trial - {1'b0, ma_reg}) : trial;
                prod_next = {prod_reg[104:0], ge};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd56)
                    state_next = F_NORM;
            end
            F_NORM:
            begin
                if (op_reg == FOP_MUL)
                begin
                    if (prod_reg[105])
                    begin
                        sig_next = prod_reg[105:50];
                        stk_next = |prod_reg[49:0];
                        exp_next = ea_reg + eb_reg + 14'sd1;
                    end
                    else
                    begin
                        sig_next = prod_reg[104:49];
                        stk_next = |prod_reg[48:0];
                        exp_next = ea_reg + eb_reg;
                    end
                end
                else
                begin
                    if (prod_reg[56])
                    begin
                        sig_next = prod_reg[56:1];
                        stk_next = prod_reg[0] | (rem_reg != '0);
                        exp_next = -ea_reg;
                    end
                    else
                    begin
                        sig_next = prod_reg[55:0];
                        stk_next = rem_reg != '0;
                        exp_next = -ea_reg - 14'sd1;
                    end
                end
                state_next = F_ROUND;
            end
            F_ROUND:
            begin
                res_next   = packed_res;
                state_next = F_DONE;
            end
            F_DONE:
                state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        sign_reg <= sign_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        sig_reg  <= sig_next;
        stk_reg  <= stk_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = (state_reg == F_DONE);
    assign rsp.result = res_reg;

endmodule

>>> rtl/float_integer_power.sv
`timescale 1ns / 1ps
// Top level of the float integer power block: double base to an integer power.
// Depends on fip_pkg, fip_in_if, fip_out_if and fip_fpu.
//
//   Channel  Direction  Payload                           Width
//   in_ch    sink       base_bits, power                  64, EXPONENT_WIDTH
//   out_ch   source     result_bits                       64
//
// One item is worked on at a time. The exponent magnitude is scanned from its
// top bit down; each bit costs a squaring on the shared multiplier and a step
// state, plus, when the bit is set, a multiply by the base. A negative exponent
// adds a reciprocal on the same unit, computed by the restoring divider that
// yields one quotient bit per cycle. An operation on a special operand (zero,
// infinity, NaN) goes from unpacking straight to done in the unit.
// Reset returns the sequencer to idle; in_ch.ready is high only while idle.
// A result waits in the output register while out_ch.ready is low.
module float_integer_power #(
    parameter int EXPONENT_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    fip_in_if.sink    in_ch,
    fip_out_if.source out_ch
);
    import fip_pkg::*;

    localparam int IdxW = $clog2(EXPONENT_WIDTH);

    top_state_t                state_reg, state_next;
    logic [IdxW-1:0]           idx_reg, idx_next;
    logic [EXPONENT_WIDTH-1:0] mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic [63:0]               base_reg, base_next;
    logic [63:0]               acc_reg, acc_next;
    logic [63:0]               result_reg, result_next;

    fip_req_t req;
    fip_rsp_t rsp;

    logic [EXPONENT_WIDTH-1:0] p_in;

    // Negating the most negative exponent wraps to itself, which is exactly
    // its magnitude read as unsigned.
    assign p_in = EXPONENT_WIDTH'(in_ch.power);

    fip_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        req.start   = 1'b0;
        req.op      = FOP_MUL;
        req.a       = acc_reg;
        req.b       = acc_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_ch.valid)
                begin
                    base_next  = in_ch.base_bits;
                    neg_next   = p_in[EXPONENT_WIDTH-1];
                    mag_next   = p_in[EXPONENT_WIDTH-1] ? (~p_in + EXPONENT_WIDTH'(1))
                                                         : p_in;
                    idx_next   = IdxW'(EXPONENT_WIDTH - 1);
                    acc_next   = DBL_ONE;
                    state_next = T_SQ_GO;
                end
            end
            T_SQ_GO:
            begin
                req.start  = 1'b1;
                state_next = T_SQ_WAIT;
            end
            T_SQ_WAIT:
            begin
                if (rsp.done)
                begin
                    acc_next   = rsp.result;
                    state_next = mag_reg[idx_reg] ? T_MB_GO : T_STEP;
                end
            end
            T_MB_GO:
            begin
                req.start  = 1'b1;
                req.b      = base_reg;
                state_next = T_MB_WAIT;
            end
            T_MB_WAIT:
            begin
                req.b = base_reg;
                if (rsp.done)
                begin
                    acc_next   = rsp.result;
                    state_next = T_STEP;
                end
            end
            T_STEP:
            begin
                if (idx_reg == '0)
                begin
                    result_next = acc_reg;
                    state_next  = neg_reg ? T_DIV_GO : T_OUT;
                end
                else
                begin
                    idx_next   = idx_reg - IdxW'(1);
                    state_next = T_SQ_GO;
                end
            end
            T_DIV_GO:
            begin
                req.start  = 1'b1;
                req.op     = FOP_RECIP;
                state_next = T_DIV_WAIT;
            end
            T_DIV_WAIT:
            begin
                req.op = FOP_RECIP;
                if (rsp.done)
                begin
                    result_next = rsp.result;
                    state_next  = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_ch.ready)
                    state_next = T_IDLE;
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign in_ch.ready        = (state_reg == T_IDLE);
    assign out_ch.valid       = (state_reg == T_OUT);
    assign out_ch.result_bits = result_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for float_integer_power: base to an integer power.
// Depends on fip_pkg, fip_in_if, fip_out_if and the RTL of the block.
module tb_top;
    import fip_pkg::*;

    localparam int PowerWidth  = 32;
    localparam int RandomItems = 1750;
    localparam int QuietTail   = 150;
    localparam int LongHold    = 3000;
    // The limit is several times the whole run with every item at the slowest
    // rate, plus the long hold and the idle bursts.
    localparam longint CycleLimit = 64'd6_000_000;
    localparam int DrainCycles    = 1000;

    typedef struct {
        logic                  pause;
        logic [63:0]           base_bits;
        logic [PowerWidth-1:0] power;
    } power_item_t;

    logic clk;
    logic rst_n;

    fip_in_if #(.PowerWidth(PowerWidth)) in_ch ();
    fip_out_if out_ch ();

    float_integer_power #(.EXPONENT_WIDTH(PowerWidth)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Items waiting to be offered, and the results predicted for accepted items.
    power_item_t pending_items[$];
    logic [63:0] expected_results[$];

    int     mismatch_count;
    int     sent_count;
    int     checked_count;
    int     total_items;
    int     send_gap;
    int     recv_gap;
    int     hold_left;
    bit     hold_done;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Predicts base ** power in the same order of rounded products as the block:
    // square, then multiply by the base for each set bit of the magnitude.
    function automatic logic [63:0] power_by_squaring(
        input logic [63:0] base_bits,
        input logic [PowerWidth-1:0] power
    );
        real                   base;
        real                   acc;
        logic [PowerWidth-1:0] magnitude;
        logic                  negative;
        logic [63:0]           acc_bits;
        base = $bitstoreal(base_bits);
        acc = 1.0;
        negative = power[PowerWidth-1];
        // Negating the most negative exponent yields its own pattern, which is
        // exactly the magnitude 2^(PowerWidth-1) that is wanted.
        magnitude = negative ? -power : power;
        for (int i = PowerWidth - 1; i >= 0; i--)
        begin
            acc = acc * acc;
            if (magnitude[i])
            begin
                acc = acc * base;
            end
        end
        acc_bits = $realtobits(acc);
        if (!negative)
        begin
            return acc_bits;
        end
        // The reciprocal of a signed zero is the infinity of the same sign.
        if (acc == 0.0)
        begin
            return {acc_bits[63], DBL_INF[62:0]};
        end
        return $realtobits(1.0 / acc);
    endfunction

    // Bases are drawn mostly near one in magnitude, so that long exponents still
    // give finite, rounded results; the rest cover every class of double.
    function automatic logic [63:0] random_base();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: bits[62:52] = 11'h3FF - 11'($urandom_range(0, 1));
            4: bits[62:52] = 11'h3F0 + 11'($urandom_range(0, 31));
            5: bits[62:52] = 11'h000;
            6: bits[62:52] = 11'h7FF;
            7: bits[51:0] = 52'h0;
            default: ;
        endcase
        return bits;
    endfunction

    function automatic logic [PowerWidth-1:0] random_power();
        logic [PowerWidth-1:0] value;
        case ($urandom_range(0, 7))
            0, 1, 2: value = PowerWidth'($signed($urandom_range(0, 128)) - 64);
            3, 4: value = PowerWidth'($signed($urandom_range(0, 4096)) - 2048);
            5: value = PowerWidth'($urandom);
            6: value = {$urandom_range(0, 1) == 1, {(PowerWidth - 1){1'b0}}}
                       | PowerWidth'($urandom_range(0, 3));
            default: value = {PowerWidth{1'b1}} ^ PowerWidth'($urandom_range(0, 3));
        endcase
        return value;
    endfunction

    task automatic add_item(input logic [63:0] base_bits, input logic [PowerWidth-1:0] power);
        power_item_t item;
        item.pause = 1'b0;
        item.base_bits = base_bits;
        item.power = power;
        pending_items.push_back(item);
    endtask

    task automatic add_pause();
        power_item_t item;
        item.pause = 1'b1;
        item.base_bits = '0;
        item.power = '0;
        pending_items.push_back(item);
    endtask

    // Driver: offers the next pending item, with random idle bursts. A pause
    // entry holds the channel quiet until every expected result has arrived.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.base_bits <= '0;
            in_ch.power     <= '0;
            send_gap        <= 0;
            sent_count      <= 0;
        end
        else
        begin : drive
            logic accepted;
            accepted = in_ch.valid && in_ch.ready;
            if (accepted)
            begin
                expected_results.push_back(power_by_squaring(in_ch.base_bits, in_ch.power));
                sent_count <= sent_count + 1;
            end
            if (!in_ch.valid || accepted)
            begin
                if (pending_items.size() > 0 && pending_items[0].pause)
                begin
                    in_ch.valid <= 1'b0;
                    if (!accepted && expected_results.size() == 0)
                    begin
                        void'(pending_items.pop_front());
                    end
                end
                else if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (sent_count < total_items - QuietTail && accepted
                         && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 2);
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_ch.valid     <= 1'b1;
                    in_ch.base_bits <= pending_items[0].base_bits;
                    in_ch.power     <= pending_items[0].power;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold, counted on its own: once early on the receiver stays
    // off so that the block holds a finished result and keeps its input closed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && checked_count == 40)
        begin
            hold_done <= 1'b1;
            hold_left <= LongHold;
        end
    end

    // Monitor: compares every result with the oldest prediction. The receiver
    // stalls in short random bursts and during the long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready   <= 1'b0;
            recv_gap       <= 0;
            checked_count  <= 0;
            mismatch_count <= 0;
        end
        else
        begin : check
            logic [63:0] want;
            if (out_ch.valid && out_ch.ready)
            begin
                checked_count <= checked_count + 1;
                if (expected_results.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                    begin
                        $display("Unexpected result_bits %h with nothing expected",
                                 out_ch.result_bits);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.result_bits !== want)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                        begin
                            $display("Mismatch on result_bits: expected %h, got %h",
                                     want, out_ch.result_bits);
                        end
                    end
                end
            end
            if (hold_left > 0 || (!hold_done && checked_count == 40))
            begin
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (checked_count < total_items - QuietTail && out_ch.ready
                     && $urandom_range(0, 7) == 0)
            begin
                recv_gap <= $urandom_range(0, 2);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        in_ch.valid = 1'b0;
        in_ch.base_bits = '0;
        in_ch.power = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;

        // Directed items: zero exponent with odd bases, both signs of zero and
        // infinity, NaN, subnormals, and the extreme exponents.
        add_item(64'hFFF8_0000_0000_0001, '0);
        add_item(64'h7FF0_0000_0000_0001, '0);
        add_item(DBL_ONE, {1'b1, {(PowerWidth - 1){1'b0}}});
        add_item(64'h3FF0_0000_0000_0001, {1'b1, {(PowerWidth - 1){1'b0}}});
        add_item(64'h4000_0000_0000_0000, {1'b0, {(PowerWidth - 1){1'b1}}});
        add_item(64'hBFF0_0000_0000_0000, {1'b0, {(PowerWidth - 1){1'b1}}});
        add_item(64'h0000_0000_0000_0000, -PowerWidth'(1));
        add_item(64'h8000_0000_0000_0000, -PowerWidth'(3));
        add_item(64'h8000_0000_0000_0000, PowerWidth'(3));
        add_item(64'h0000_0000_0000_0001, -PowerWidth'(2));
        add_item(64'h0000_0000_0000_0001, PowerWidth'(1));
        add_item(64'h800F_FFFF_FFFF_FFFF, PowerWidth'(1));
        add_item(64'h7FF0_0000_0000_0000, -PowerWidth'(1));
        add_item(64'hFFF0_0000_0000_0000, PowerWidth'(3));
        add_item(64'hFFF0_0000_0000_0000, -PowerWidth'(2));
        add_item(64'h7FF4_0000_0000_0000, PowerWidth'(5));
        add_item(64'h7FEF_FFFF_FFFF_FFFF, PowerWidth'(2));
        add_item(64'h3FE0_0000_0000_0000, PowerWidth'(1074));
        add_item(64'h3FE0_0000_0000_0000, PowerWidth'(1075));
        add_item(64'h3FF8_0000_0000_0000, -PowerWidth'(7));
        add_item(64'hC000_0000_0000_0000, PowerWidth'(1023));
        add_item(64'h4000_0000_0000_0000, PowerWidth'(1024));
        add_item(64'h3FF0_0000_0000_0001, {PowerWidth{1'b1}});
        add_item({$urandom, $urandom}, {1'b1, {(PowerWidth - 1){1'b0}}} | PowerWidth'(1));

        for (int i = 0; i < RandomItems; i++)
        begin
            if (i == RandomItems / 2)
            begin
                add_pause();
            end
            add_item(random_base(), random_power());
        end
        total_items = pending_items.size() - 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0 && sent_count == total_items);
        wait (expected_results.size() == 0);
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> float_integer_power.f
rtl/fip_pkg.sv
rtl/fip_in_if.sv
rtl/fip_out_if.sv
rtl/fip_fpu.sv
rtl/float_integer_power.sv
sim/tb_top.sv
